[hdl/gameport_axis_timer_top_defines.svh]
// assertion macros used by the checker file of the game port axis timer
`ifndef GAMEPORT_AXIS_TIMER_TOP_DEFINES_SVH
`define GAMEPORT_AXIS_TIMER_TOP_DEFINES_SVH

// property that must hold in the same cycle as its trigger
`define GAT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// property that must hold in the cycle after its trigger
`define GAT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/gat_pkg.sv]
// shared types and constants for the game port axis timer
`default_nettype none
package gat_pkg;

  localparam int unsigned CNT_W = 16;
  localparam int unsigned NUM_W = CNT_W + 7;
  localparam int unsigned DEN_W = CNT_W + 1;
  localparam int unsigned MAG_W = 7;
  localparam int unsigned STEP_W = 3;

  localparam logic [CNT_W-1:0] MAX_SAMPLES = 16'hFFFF;
  localparam logic [MAG_W-1:0] MAG_SAT = 7'd127;
  localparam logic [STEP_W-1:0] DIV_STEPS = 3'd7;

  // command codes
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  // configuration register indexes
  localparam logic [1:0] REG_JOY_SEL = 2'd0;
  localparam logic [1:0] REG_CENTER_X = 2'd1;
  localparam logic [1:0] REG_CENTER_Y = 2'd2;

  // status byte bit positions, joystick a and b
  localparam logic [2:0] PB_AXIS_X_A = 3'd0;
  localparam logic [2:0] PB_AXIS_Y_A = 3'd1;
  localparam logic [2:0] PB_AXIS_X_B = 3'd2;
  localparam logic [2:0] PB_AXIS_Y_B = 3'd3;
  localparam logic [2:0] PB_BTN1_A = 3'd4;
  localparam logic [2:0] PB_BTN2_A = 3'd5;
  localparam logic [2:0] PB_BTN1_B = 3'd6;
  localparam logic [2:0] PB_BTN2_B = 3'd7;

  localparam logic AXIS_X = 1'b0;
  localparam logic AXIS_Y = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MEAS,
    ST_LOAD_X,
    ST_RUN_X,
    ST_LOAD_Y,
    ST_RUN_Y,
    ST_OUT
  } gat_state_t;

  typedef struct packed {
    logic start_en;
    logic sample_en;
    logic div_load;
    logic div_step;
    logic div_capture;
    logic div_axis;
    logic out_load;
  } gat_cmd_t;

  typedef struct packed {
    logic meas_end;
    logic div_done;
    logic out_busy;
  } gat_sts_t;

endpackage
`default_nettype wire

[hdl/gat_datapath.sv]
// counters, configuration registers, shared divider and result register
`default_nettype none
module gat_datapath (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire gat_pkg::gat_cmd_t             cmd,
  output gat_pkg::gat_sts_t                  sts,
  input  wire logic [7:0]                    in_port_bits,
  input  wire logic                          cfg_valid,
  input  wire logic                          cfg_ready,
  input  wire logic [1:0]                    cfg_index,
  input  wire logic [15:0]                   cfg_data,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               out_present,
  output logic                               out_button_one,
  output logic                               out_button_two,
  output logic [15:0]                        out_x_count,
  output logic [15:0]                        out_y_count,
  output logic signed [7:0]                  out_delta_x,
  output logic signed [7:0]                  out_delta_y
);

  logic                          joy_sel_r;
  logic [gat_pkg::CNT_W-1:0]     center_x_r, center_y_r;
  logic [1:0]                    held_btn_r, held_btn_nxt;
  logic [gat_pkg::CNT_W-1:0]     x_cnt_r, x_cnt_nxt, y_cnt_r, y_cnt_nxt;
  logic [gat_pkg::CNT_W-1:0]     smp_cnt_r, smp_cnt_nxt;
  logic                          x_fin_r, x_fin_nxt, y_fin_r, y_fin_nxt;

  logic                          bit_x, bit_y, btn1, btn2;
  logic                          x_inc, y_inc, x_fin_s, y_fin_s;
  logic [gat_pkg::CNT_W:0]       smp_plus1;

  logic [gat_pkg::CNT_W-1:0]     cnt_sel, ctr_sel, diff;
  logic                          above;
  logic [gat_pkg::NUM_W-1:0]     num;
  logic [gat_pkg::DEN_W-1:0]     den;
  logic                          sat;

  logic [gat_pkg::NUM_W-1:0]     rem_r, rem_nxt, den_sh_r, den_sh_nxt;
  logic [gat_pkg::MAG_W-1:0]     q_r, q_nxt, mag;
  logic [gat_pkg::STEP_W-1:0]    step_r, step_nxt;
  logic                          sat_r, sat_nxt, neg_r, neg_nxt;
  logic [7:0]                    delta_res;
  logic [7:0]                    dx_r, dx_nxt, dy_r, dy_nxt;

  logic                          cal_ok;
  logic                          out_valid_r, out_valid_nxt;
  logic                          present_r;
  logic                          btn1_r, btn2_r;
  logic [gat_pkg::CNT_W-1:0]     ox_r, oy_r;
  logic [7:0]                    odx_r, ody_r;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      joy_sel_r  <= 1'b0;
      center_x_r <= '0;
      center_y_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        gat_pkg::REG_JOY_SEL:  joy_sel_r  <= cfg_data[0];
        gat_pkg::REG_CENTER_X: center_x_r <= cfg_data;
        gat_pkg::REG_CENTER_Y: center_y_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // bit selection for the chosen joystick
  assign bit_x = joy_sel_r ? in_port_bits[gat_pkg::PB_AXIS_X_B]
                           : in_port_bits[gat_pkg::PB_AXIS_X_A];
  assign bit_y = joy_sel_r ? in_port_bits[gat_pkg::PB_AXIS_Y_B]
                           : in_port_bits[gat_pkg::PB_AXIS_Y_A];
  assign btn1  = joy_sel_r ? in_port_bits[gat_pkg::PB_BTN1_B]
                           : in_port_bits[gat_pkg::PB_BTN1_A];
  assign btn2  = joy_sel_r ? in_port_bits[gat_pkg::PB_BTN2_B]
                           : in_port_bits[gat_pkg::PB_BTN2_A];

  assign x_inc   = bit_x & ~x_fin_r;
  assign y_inc   = bit_y & ~y_fin_r;
  assign x_fin_s = x_fin_r | ~bit_x;
  assign y_fin_s = y_fin_r | ~bit_y;
  assign smp_plus1 = {1'b0, smp_cnt_r} + {{gat_pkg::CNT_W{1'b0}}, 1'b1};

  assign sts.meas_end = (smp_plus1 >= {1'b0, gat_pkg::MAX_SAMPLES}) || (x_fin_s && y_fin_s);

  always_comb begin
    held_btn_nxt = held_btn_r;
    x_cnt_nxt    = x_cnt_r;
    y_cnt_nxt    = y_cnt_r;
    smp_cnt_nxt  = smp_cnt_r;
    x_fin_nxt    = x_fin_r;
    y_fin_nxt    = y_fin_r;
    if (cmd.start_en) begin
      held_btn_nxt = {btn2, btn1};
      x_cnt_nxt    = '0;
      y_cnt_nxt    = '0;
      smp_cnt_nxt  = '0;
      x_fin_nxt    = 1'b0;
      y_fin_nxt    = 1'b0;
    end else if (cmd.sample_en) begin
      x_cnt_nxt   = x_cnt_r + {{(gat_pkg::CNT_W-1){1'b0}}, x_inc};
      y_cnt_nxt   = y_cnt_r + {{(gat_pkg::CNT_W-1){1'b0}}, y_inc};
      smp_cnt_nxt = smp_plus1[gat_pkg::CNT_W-1:0];
      x_fin_nxt   = x_fin_s;
      y_fin_nxt   = y_fin_s;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_btn_r <= '0;
      x_cnt_r    <= '0;
      y_cnt_r    <= '0;
      smp_cnt_r  <= '0;
      x_fin_r    <= 1'b0;
      y_fin_r    <= 1'b0;
    end else begin
      held_btn_r <= held_btn_nxt;
      x_cnt_r    <= x_cnt_nxt;
      y_cnt_r    <= y_cnt_nxt;
      smp_cnt_r  <= smp_cnt_nxt;
      x_fin_r    <= x_fin_nxt;
      y_fin_r    <= y_fin_nxt;
    end
  end

  // divider operands: above centre the span is 2*centre, else centre
  assign cnt_sel = (cmd.div_axis == gat_pkg::AXIS_Y) ? y_cnt_r : x_cnt_r;
  assign ctr_sel = (cmd.div_axis == gat_pkg::AXIS_Y) ? center_y_r : center_x_r;
  assign above   = cnt_sel > ctr_sel;
  assign diff    = above ? (cnt_sel - ctr_sel) : (ctr_sel - cnt_sel);
  assign num     = {diff, 7'b0} - {7'b0, diff};
  assign den     = above ? {ctr_sel, 1'b0} : {1'b0, ctr_sel};
  // quotient of 128 or more saturates
  assign sat     = {1'b0, num} >= {den, 7'b0};

  // restoring division, one quotient bit per step, msb first
  always_comb begin
    rem_nxt    = rem_r;
    den_sh_nxt = den_sh_r;
    q_nxt      = q_r;
    step_nxt   = step_r;
    sat_nxt    = sat_r;
    neg_nxt    = neg_r;
    if (cmd.div_load) begin
      rem_nxt    = num;
      den_sh_nxt = {den, 6'b0};
      q_nxt      = '0;
      step_nxt   = gat_pkg::DIV_STEPS;
      sat_nxt    = sat;
      neg_nxt    = ~above;
    end else if (cmd.div_step) begin
      if (rem_r >= den_sh_r) begin
        rem_nxt = rem_r - den_sh_r;
        q_nxt   = {q_r[gat_pkg::MAG_W-2:0], 1'b1};
      end else begin
        q_nxt   = {q_r[gat_pkg::MAG_W-2:0], 1'b0};
      end
      den_sh_nxt = den_sh_r >> 1;
      step_nxt   = step_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
    end else begin
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r    <= rem_nxt;
    den_sh_r <= den_sh_nxt;
    q_r      <= q_nxt;
    sat_r    <= sat_nxt;
    neg_r    <= neg_nxt;
  end

  assign sts.div_done = (step_r == '0);

  assign mag       = sat_r ? gat_pkg::MAG_SAT : q_r;
  assign delta_res = neg_r ? (8'd0 - {1'b0, mag}) : {1'b0, mag};

  always_comb begin
    dx_nxt = dx_r;
    dy_nxt = dy_r;
    if (cmd.div_capture) begin
      if (cmd.div_axis == gat_pkg::AXIS_Y) begin
        dy_nxt = delta_res;
      end else begin
        dx_nxt = delta_res;
      end
    end
  end

  always_ff @(posedge clk) begin
    dx_r <= dx_nxt;
    dy_r <= dy_nxt;
  end

  // result register
  assign cal_ok = (center_x_r != '0) && (center_y_r != '0);
  assign out_valid_nxt = cmd.out_load | (out_valid_r & out_stall);
  assign sts.out_busy  = out_valid_r & out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      present_r <= cal_ok && (x_cnt_r != gat_pkg::MAX_SAMPLES)
                          && (y_cnt_r != gat_pkg::MAX_SAMPLES);
      btn1_r    <= held_btn_r[0];
      btn2_r    <= held_btn_r[1];
      ox_r      <= x_cnt_r;
      oy_r      <= y_cnt_r;
      odx_r     <= cal_ok ? dx_r : 8'd0;
      ody_r     <= cal_ok ? dy_r : 8'd0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_present    = present_r;
  assign out_button_one = btn1_r;
  assign out_button_two = btn2_r;
  assign out_x_count    = ox_r;
  assign out_y_count    = oy_r;
  assign out_delta_x    = $signed(odx_r);
  assign out_delta_y    = $signed(ody_r);

endmodule
`default_nettype wire

[hdl/gat_ctrl.sv]
// sequencing state machine for measurement, division and result hand-off
`default_nettype none
module gat_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire logic               in_command,
  output logic                    in_stall,
  input  wire gat_pkg::gat_sts_t  sts,
  output gat_pkg::gat_cmd_t       cmd
);

  gat_pkg::gat_state_t state_r, state_nxt;
  logic                open_s;
  logic                accept_s;

  assign open_s   = (state_r == gat_pkg::ST_IDLE) || (state_r == gat_pkg::ST_MEAS);
  assign accept_s = in_valid && open_s;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      gat_pkg::ST_IDLE: begin
        if (accept_s && in_command == gat_pkg::CMD_START) state_nxt = gat_pkg::ST_MEAS;
      end
      gat_pkg::ST_MEAS: begin
        if (accept_s && in_command == gat_pkg::CMD_SAMPLE && sts.meas_end) begin
          state_nxt = gat_pkg::ST_LOAD_X;
        end
      end
      gat_pkg::ST_LOAD_X: state_nxt = gat_pkg::ST_RUN_X;
      gat_pkg::ST_RUN_X: begin
        if (sts.div_done) state_nxt = gat_pkg::ST_LOAD_Y;
      end
      gat_pkg::ST_LOAD_Y: state_nxt = gat_pkg::ST_RUN_Y;
      gat_pkg::ST_RUN_Y: begin
        if (sts.div_done) state_nxt = gat_pkg::ST_OUT;
      end
      gat_pkg::ST_OUT: begin
        if (!sts.out_busy) state_nxt = gat_pkg::ST_IDLE;
      end
      default: state_nxt = gat_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall        = !open_s;
    cmd             = '0;
    cmd.start_en    = accept_s && (in_command == gat_pkg::CMD_START);
    cmd.sample_en   = accept_s && (in_command == gat_pkg::CMD_SAMPLE)
                      && (state_r == gat_pkg::ST_MEAS);
    case (state_r)
      gat_pkg::ST_LOAD_X: begin
        cmd.div_load = 1'b1;
        cmd.div_axis = gat_pkg::AXIS_X;
      end
      gat_pkg::ST_RUN_X: begin
        cmd.div_axis    = gat_pkg::AXIS_X;
        cmd.div_step    = !sts.div_done;
        cmd.div_capture = sts.div_done;
      end
      gat_pkg::ST_LOAD_Y: begin
        cmd.div_load = 1'b1;
        cmd.div_axis = gat_pkg::AXIS_Y;
      end
      gat_pkg::ST_RUN_Y: begin
        cmd.div_axis    = gat_pkg::AXIS_Y;
        cmd.div_step    = !sts.div_done;
        cmd.div_capture = sts.div_done;
      end
      gat_pkg::ST_OUT: begin
        cmd.out_load = !sts.out_busy;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gat_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

[hdl/gameport_axis_timer_top.sv]
// top level of the game port joystick axis timer
//
//   channel | dir | handshake             | payload
//   in_     | in  | in_valid / in_stall   | in_command, in_port_bits
//   out_    | out | out_valid / out_stall | present, buttons, counts, deltas
//   cfg_    | in  | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// start and sample transactions are accepted while idle or measuring
// the sample that ends a measurement is followed by the division work (two 7-step
// restoring divisions, one per axis, in a shared divider) with in_stall high
// in_stall also stays high while a new result waits for the previous one to leave the output register
// synchronous active-low reset clears all control state; cfg_ready is always high
`default_nettype none
module gameport_axis_timer_top (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic              in_command,
  input  wire logic [7:0]        in_port_bits,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic                   out_present,
  output logic                   out_button_one,
  output logic                   out_button_two,
  output logic [15:0]            out_x_count,
  output logic [15:0]            out_y_count,
  output logic signed [7:0]      out_delta_x,
  output logic signed [7:0]      out_delta_y,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [15:0]       cfg_data
);

  gat_pkg::gat_cmd_t cmd;
  gat_pkg::gat_sts_t sts;

  assign cfg_ready = 1'b1;

  gat_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_command),
    .in_stall   (in_stall),
    .sts        (sts),
    .cmd        (cmd)
  );

  gat_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_port_bits   (in_port_bits),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_present    (out_present),
    .out_button_one (out_button_one),
    .out_button_two (out_button_two),
    .out_x_count    (out_x_count),
    .out_y_count    (out_y_count),
    .out_delta_x    (out_delta_x),
    .out_delta_y    (out_delta_y)
  );

endmodule
`default_nettype wire

[hdl/gat_checker.sv]
// port-level checker for the game port axis timer, bound to the top level
`default_nettype none
`include "gameport_axis_timer_top_defines.svh"
module gat_checker (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_stall,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire logic              out_present,
  input wire logic [15:0]       out_x_count,
  input wire logic [15:0]       out_y_count,
  input wire logic signed [7:0] out_delta_x,
  input wire logic signed [7:0] out_delta_y
);

  // a held result keeps its counts
  `GAT_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
    out_valid && $stable(out_x_count) && $stable(out_y_count), "stalled result changed")

  // deltas never reach -128
  `GAT_ASSERT_NOW(a_delta_range, out_valid, out_delta_x != 8'sh80 && out_delta_y != 8'sh80, "delta out of range")

  // a timed-out axis cannot be reported as present
  `GAT_ASSERT_NOW(a_present_timeout, out_valid && out_present,
    out_x_count != 16'hFFFF && out_y_count != 16'hFFFF, "present despite timeout")

  // a new result is only loaded while the input side is held off
  `GAT_ASSERT_NOW(a_load_stalled, $rose(out_valid), $past(in_stall), "result loaded while input open")

endmodule

bind gameport_axis_timer_top gat_checker u_gat_checker (.*);
`default_nettype wire

[verif/gameport_axis_timer_checker.sv]
`timescale 1ns / 1ps
// reading predictor and scoreboard for the game port axis timer
module gameport_axis_timer_checker
  import gat_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic              in_command,
  input  logic [7:0]        in_port_bits,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic              out_present,
  input  logic              out_button_one,
  input  logic              out_button_two,
  input  logic [15:0]       out_x_count,
  input  logic [15:0]       out_y_count,
  input  logic signed [7:0] out_delta_x,
  input  logic signed [7:0] out_delta_y,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [15:0]       cfg_data,
  output int                fail_count,
  output int                pending,
  output int                readings,
  output int                absent
);

  typedef struct packed {
    logic              present;
    logic              btn_one;
    logic              btn_two;
    logic [15:0]       x_cnt;
    logic [15:0]       y_cnt;
    logic signed [7:0] dx;
    logic signed [7:0] dy;
  } reading_t;

  reading_t    want_q[$];
  reading_t    want;
  reading_t    got;

  // predicted register file and measurement state
  logic        joy_sel;
  logic [15:0] cal_x;
  logic [15:0] cal_y;
  logic        measuring;
  logic        x_done;
  logic        y_done;
  logic [15:0] x_cnt;
  logic [15:0] y_cnt;
  logic [15:0] n_samples;
  logic [1:0]  held_btn;
  logic        axis_x;
  logic        axis_y;
  logic        cal_ok;

  // above the centre the full scale is twice the centre, below it is the centre
  function automatic logic [7:0] axis_delta(input logic [15:0] count, input logic [15:0] centre);
    int unsigned c;
    int unsigned m;
    int unsigned mag;
    c = count;
    m = centre;
    if (c > m) begin
      mag = ((c - m) * 127) / (2 * m);
      if (mag > MAG_SAT) mag = MAG_SAT;
      return 8'(mag);
    end
    mag = ((m - c) * 127) / m;
    if (mag > MAG_SAT) mag = MAG_SAT;
    return 8'(256 - mag);
  endfunction

  function automatic void field_check(input string what, input int want_v, input int got_v);
    if (want_v != got_v) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want_v, got_v);
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      joy_sel = 1'b0;
      cal_x = '0;
      cal_y = '0;
      measuring = 1'b0;
      x_done = 1'b0;
      y_done = 1'b0;
      x_cnt = '0;
      y_cnt = '0;
      n_samples = '0;
      held_btn = '0;
      want_q.delete();
      pending = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_JOY_SEL: joy_sel = cfg_data[0];
          REG_CENTER_X: cal_x = cfg_data;
          REG_CENTER_Y: cal_y = cfg_data;
          default: ;
        endcase
      end

      if (in_valid && !in_stall) begin
        if (in_command == CMD_START) begin
          held_btn = {in_port_bits[joy_sel ? PB_BTN2_B : PB_BTN2_A],
                      in_port_bits[joy_sel ? PB_BTN1_B : PB_BTN1_A]};
          x_cnt = '0;
          y_cnt = '0;
          x_done = 1'b0;
          y_done = 1'b0;
          n_samples = '0;
          measuring = 1'b1;
        end else if (measuring) begin
          axis_x = in_port_bits[joy_sel ? PB_AXIS_X_B : PB_AXIS_X_A];
          axis_y = in_port_bits[joy_sel ? PB_AXIS_Y_B : PB_AXIS_Y_A];
          // an axis stays finished once its bit has dropped
          if (axis_x && !x_done) x_cnt++;
          else x_done = 1'b1;
          if (axis_y && !y_done) y_cnt++;
          else y_done = 1'b1;
          n_samples++;
          if (n_samples == MAX_SAMPLES || (x_done && y_done)) begin
            measuring = 1'b0;
            cal_ok = (cal_x != 0) && (cal_y != 0);
            want.present = cal_ok && (x_cnt != MAX_SAMPLES) && (y_cnt != MAX_SAMPLES);
            want.btn_one = held_btn[0];
            want.btn_two = held_btn[1];
            want.x_cnt = x_cnt;
            want.y_cnt = y_cnt;
            want.dx = cal_ok ? axis_delta(x_cnt, cal_x) : 8'sd0;
            want.dy = cal_ok ? axis_delta(y_cnt, cal_y) : 8'sd0;
            want_q.push_back(want);
          end
        end
      end

      if (out_valid && !out_stall) begin
        got.present = out_present;
        got.btn_one = out_button_one;
        got.btn_two = out_button_two;
        got.x_cnt = out_x_count;
        got.y_cnt = out_y_count;
        got.dx = out_delta_x;
        got.dy = out_delta_y;
        if (want_q.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected reading, expected none, got x_count %0d y_count %0d",
                   $time, got.x_cnt, got.y_cnt);
        end else begin
          want = want_q.pop_front();
          field_check("present", want.present, got.present);
          field_check("button_one", want.btn_one, got.btn_one);
          field_check("button_two", want.btn_two, got.btn_two);
          field_check("x_count", want.x_cnt, got.x_cnt);
          field_check("y_count", want.y_cnt, got.y_cnt);
          field_check("delta_x", $signed(want.dx), $signed(got.dx));
          field_check("delta_y", $signed(want.dy), $signed(got.dy));
          readings++;
          if (!got.present) absent++;
        end
      end
      pending = want_q.size();
    end
  end

endmodule

[verif/gameport_axis_timer_top_tb.sv]
`timescale 1ns / 1ps
// stimulus, flow control and verdict for the game port axis timer
module gameport_axis_timer_top_tb;
  import gat_pkg::*;

  localparam int CLK_HALF = 2;
  localparam int RESET_CYCLES = 12;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 40;
  localparam int PHASE_ITEMS = 150;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              in_command = 1'b0;
  logic [7:0]        in_port_bits = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              out_present;
  logic              out_button_one;
  logic              out_button_two;
  logic [15:0]       out_x_count;
  logic [15:0]       out_y_count;
  logic signed [7:0] out_delta_x;
  logic signed [7:0] out_delta_y;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [1:0]        cfg_index = '0;
  logic [15:0]       cfg_data = '0;

  int   idle_pct = 0;
  int   stall_pct = 0;
  bit   hold_req = 1'b0;
  logic cur_joy = 1'b0;
  int   items_sent = 0;
  int   cycles = 0;
  int   fail_count;
  int   pending;
  int   readings;
  int   absent;

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  gameport_axis_timer_top dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_command     (in_command),
    .in_port_bits   (in_port_bits),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_present    (out_present),
    .out_button_one (out_button_one),
    .out_button_two (out_button_two),
    .out_x_count    (out_x_count),
    .out_y_count    (out_y_count),
    .out_delta_x    (out_delta_x),
    .out_delta_y    (out_delta_y),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  gameport_axis_timer_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_command     (in_command),
    .in_port_bits   (in_port_bits),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_present    (out_present),
    .out_button_one (out_button_one),
    .out_button_two (out_button_two),
    .out_x_count    (out_x_count),
    .out_y_count    (out_y_count),
    .out_delta_x    (out_delta_x),
    .out_delta_y    (out_delta_y),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .fail_count     (fail_count),
    .pending        (pending),
    .readings       (readings),
    .absent         (absent)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("gameport_axis_timer_top verification failed");
      $finish;
    end
  end

  // result side: random stalls, or one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        out_stall <= (stall_pct != 0) && ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  task automatic send_item(input logic cmd, input logic [7:0] bits);
    while (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_port_bits <= bits;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic set_config(input logic joy, input logic [15:0] cx, input logic [15:0] cy);
    write_reg(REG_JOY_SEL, {15'd0, joy});
    write_reg(REG_CENTER_X, cx);
    write_reg(REG_CENTER_Y, cy);
    cfg_valid <= 1'b0;
    cur_joy = joy;
  endtask

  // wait for every reading, then let the divider finish before touching registers
  task automatic settle();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // an optional abandoned start, then one start and samples that hold each axis high for its length
  task automatic measure(input int unsigned xl, input int unsigned yl,
                         input logic [7:0] start_bits, input bit restart);
    int unsigned n;
    int unsigned k;
    int unsigned i;
    logic [7:0]  b;
    logic [2:0]  px;
    logic [2:0]  py;
    px = cur_joy ? PB_AXIS_X_B : PB_AXIS_X_A;
    py = cur_joy ? PB_AXIS_Y_B : PB_AXIS_Y_A;
    if (restart) begin
      // up to three samples of an abandoned measurement, then a fresh start
      k = $urandom_range(0, 3);
      send_item(CMD_START, 8'($urandom));
      for (i = 0; i < k; i++) begin
        b = 8'($urandom);
        b[px] = 1'b1;
        b[py] = 1'b1;
        send_item(CMD_SAMPLE, b);
      end
      items_sent += k + 1;
    end
    send_item(CMD_START, start_bits);
    n = ((xl > yl) ? xl : yl) + 1;
    if (n > MAX_SAMPLES) n = MAX_SAMPLES;
    for (i = 0; i < n; i++) begin
      b = 8'($urandom);
      if (i < xl) b[px] = 1'b1;
      else if (i == xl) b[px] = 1'b0;
      if (i < yl) b[py] = 1'b1;
      else if (i == yl) b[py] = 1'b0;
      send_item(CMD_SAMPLE, b);
    end
    items_sent += n + 1;
  endtask

  task automatic run_phase(input int idle, input int stall, input bit hold, input logic joy,
                           input logic [15:0] cx, input logic [15:0] cy);
    int unsigned target;
    int unsigned xl;
    int unsigned yl;
    set_config(joy, cx, cy);
    idle_pct = idle;
    stall_pct = stall;
    if (hold) hold_req = 1'b1;
    target = items_sent + PHASE_ITEMS;
    while (items_sent < target) begin
      // stray samples between measurements are ignored by the block
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 3)) send_item(CMD_SAMPLE, 8'($urandom));
      end
      if ($urandom_range(0, 7) == 0) begin
        xl = $urandom_range(0, 200);
        yl = $urandom_range(0, 200);
      end else begin
        xl = $urandom_range(0, 12);
        yl = $urandom_range(0, 12);
      end
      measure(xl, yl, 8'($urandom), $urandom_range(0, 7) == 0);
    end
    settle();
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_config(1'b0, 16'd4, 16'd8);
    send_item(CMD_SAMPLE, 8'hFF);
    measure(0, 0, 8'h30, 1'b0);
    measure(3, 1, 8'h10, 1'b0);
    measure(6, 2, 8'h20, 1'b0);
    measure(1, 2, 8'hFF, 1'b1);
    settle();
    set_config(1'b1, 16'd0, 16'hFFFF);
    measure(2, 0, 8'hC0, 1'b0);
    settle();
    set_config(1'b1, 16'd3, 16'd2);
    measure(0, 3, 8'h40, 1'b0);
    settle();

    run_phase(0, 0, 1'b0, 1'b0, 16'd1, 16'hFFFF);
    run_phase(57, 0, 1'b0, 1'b1, 16'($urandom_range(1, 40)), 16'($urandom_range(1, 40)));
    run_phase(0, 57, 1'b1, 1'b0, 16'($urandom_range(1, 40)), 16'd0);
    run_phase(26, 26, 1'b0, 1'b1, 16'($urandom_range(1, 60)), 16'($urandom_range(1, 60)));

    $display("%0d input items across directed cases and four flow-control phases",
             items_sent);
    $display("%0d readings compared, %0d reporting the stick absent",
             readings, absent);
    if (fail_count == 0) begin
      $display("gameport_axis_timer_top verification clean");
    end else begin
      $display("gameport_axis_timer_top verification failed");
    end
    $finish;
  end

endmodule
